FILE: sv/bmhq_pkg.sv
// Package of shared types and codes for the binary min-heap queue.
package bmhq_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned OCC_W = 5;
  localparam int unsigned STATUS_W = 2;

  // Request codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Status codes of a result word.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // One heap entry: key in the upper bits, tag in the lower bits.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UP,
    ST_POP,
    ST_DOWN
  } state_e;

endpackage

FILE: sv/binary_min_heap_queue.sv
// Top level of the binary min-heap queue of signed keys with tags.
//
// A request word (req_type_i, key_i, tag_i) is taken at a rising edge where
// start is high and busy is low. An insert (req_type_i low) adds the pair and
// sifts it up; a remove (req_type_i high) returns the entry with the smallest
// key and sifts the last entry down from the root. Equal keys never swap.
// Every request gives exactly one result word, shown for one cycle with
// done_o high: status_o, out_key_o, out_tag_o (zero unless a remove
// succeeded) and occupancy_o, the number of entries held afterwards.
// The heap lives in one synchronous memory with two read ports and one write
// port. A sift step reads the parent (or both children) and writes one entry
// back in the same cycle. A remove first reads the root and the last entry,
// then sifts down. done_o is registered from the last step. A dropped insert
// or an empty remove answers without any sift step.
// busy is high while a sift is under way, so one request is worked at a time.
// Reset empties the queue at once; the memory contents are left as they are.
// The receiver cannot stall, so the result word needs no holding stage.
module binary_min_heap_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  req_type_i,
  input  logic signed [bmhq_pkg::KEY_W-1:0]     key_i,
  input  logic        [bmhq_pkg::TAG_W-1:0]     tag_i,
  output logic                                  done_o,
  output logic        [bmhq_pkg::STATUS_W-1:0]  status_o,
  output logic signed [bmhq_pkg::KEY_W-1:0]     out_key_o,
  output logic        [bmhq_pkg::TAG_W-1:0]     out_tag_o,
  output logic        [bmhq_pkg::OCC_W-1:0]     occupancy_o
);

  // Address width, count width (must hold CAPACITY itself) and index width
  // wide enough for the right child of the deepest slot.
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;

  bmhq_pkg::entry_t heap_mem [CAPACITY];

  bmhq_pkg::state_e state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    pos_q, pos_d;
  bmhq_pkg::entry_t x_q, x_d;
  bmhq_pkg::entry_t rdata_a_q, rdata_b_q;

  logic                             done_q, done_d;
  logic [bmhq_pkg::STATUS_W-1:0]    status_q, status_d;
  logic [bmhq_pkg::KEY_W-1:0]       out_key_q, out_key_d;
  logic [bmhq_pkg::TAG_W-1:0]       out_tag_q, out_tag_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  bmhq_pkg::entry_t mem_wdata;
  logic [AW-1:0]    raddr_a, raddr_b;

  // Child indices of the current slot and of the slot chosen this cycle.
  logic [IW-1:0]    left_idx, right_idx, next_left, next_right;
  logic             left_ok, right_ok, pick_left, pick_right;
  bmhq_pkg::entry_t winner;
  logic [AW-1:0]    winner_pos, parent_pos, grand_pos;

  // Map an index to a memory address; indices past the end read slot zero,
  // whose data is then never used.
  function automatic logic [AW-1:0] clamp_addr(input logic [IW-1:0] idx);
    logic [AW-1:0] res;
    res = '0;
    if (idx < IW'(CAPACITY)) begin
      res = idx[AW-1:0];
    end
    return res;
  endfunction

  assign busy        = (state_q != bmhq_pkg::ST_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_key_o   = out_key_q;
  assign out_tag_o   = out_tag_q;
  assign occupancy_o = bmhq_pkg::OCC_W'(count_q);

  // Sift-down comparison: the left child beats the moving entry only when
  // strictly smaller, and the right child must be strictly smaller than that.
  assign left_idx   = {1'b0, pos_q, 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign left_ok    = (left_idx < IW'(count_q));
  assign right_ok   = (right_idx < IW'(count_q));

  always_comb begin
    pick_left  = left_ok && ($signed(rdata_a_q.key) < $signed(x_q.key));
    winner     = pick_left ? rdata_a_q : x_q;
    pick_right = right_ok && ($signed(rdata_b_q.key) < $signed(winner.key));
    if (pick_right) begin
      winner     = rdata_b_q;
      winner_pos = right_idx[AW-1:0];
    end else begin
      winner_pos = left_idx[AW-1:0];
    end
  end

  assign next_left  = {1'b0, winner_pos, 1'b1};
  assign next_right = next_left + IW'(1);
  assign parent_pos = (pos_q - AW'(1)) >> 1;
  assign grand_pos  = (parent_pos == '0) ? '0 : ((parent_pos - AW'(1)) >> 1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    x_d       = x_q;
    done_d    = 1'b0;
    status_d  = status_q;
    out_key_d = out_key_q;
    out_tag_d = out_tag_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = x_q;
    raddr_a   = '0;
    raddr_b   = '0;

    case (state_q)
      bmhq_pkg::ST_IDLE: begin
        if (start) begin
          out_key_d = '0;
          out_tag_d = '0;
          status_d  = bmhq_pkg::STATUS_OK;
          if (req_type_i == bmhq_pkg::REQ_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = bmhq_pkg::STATUS_FULL;
              done_d   = 1'b1;
            end else begin
              x_d     = '{key: key_i, tag: tag_i};
              pos_d   = count_q[AW-1:0];
              count_d = count_q + CW'(1);
              if (count_q != '0) begin
                raddr_a = AW'((count_q - CW'(1)) >> 1);
              end
              state_d = bmhq_pkg::ST_UP;
            end
          end else begin
            if (count_q == '0) begin
              status_d = bmhq_pkg::STATUS_EMPTY;
              done_d   = 1'b1;
            end else begin
              raddr_a = '0;
              raddr_b = AW'(count_q - CW'(1));
              state_d = bmhq_pkg::ST_POP;
            end
          end
        end
      end

      bmhq_pkg::ST_UP: begin
        // rdata_a_q holds the parent of the hole at pos_q.
        mem_we = 1'b1;
        if ((pos_q != '0) && ($signed(x_q.key) < $signed(rdata_a_q.key))) begin
          mem_wdata = rdata_a_q;
          pos_d     = parent_pos;
          raddr_a   = grand_pos;
        end else begin
          mem_wdata = x_q;
          done_d    = 1'b1;
          state_d   = bmhq_pkg::ST_IDLE;
        end
      end

      bmhq_pkg::ST_POP: begin
        // Root on port A, last entry on port B.
        out_key_d = rdata_a_q.key;
        out_tag_d = rdata_a_q.tag;
        x_d       = rdata_b_q;
        pos_d     = '0;
        count_d   = count_q - CW'(1);
        raddr_a   = clamp_addr(IW'(1));
        raddr_b   = clamp_addr(IW'(2));
        state_d   = bmhq_pkg::ST_DOWN;
      end

      bmhq_pkg::ST_DOWN: begin
        if (pick_left || pick_right) begin
          mem_we    = 1'b1;
          mem_wdata = winner;
          pos_d     = winner_pos;
          raddr_a   = clamp_addr(next_left);
          raddr_b   = clamp_addr(next_right);
        end else begin
          // Nothing to write back when the heap has just become empty.
          mem_we    = (IW'(pos_q) < IW'(count_q));
          mem_wdata = x_q;
          done_d    = 1'b1;
          state_d   = bmhq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bmhq_pkg::ST_IDLE;
      end
    endcase
  end

  // Heap memory: one write and two registered reads per cycle. A write and a
  // read in the same cycle never meet at one slot, as the next level's reads
  // always lie above or below the slot being written, so no bypass is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    rdata_a_q <= heap_mem[raddr_a];
    rdata_b_q <= heap_mem[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhq_pkg::ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    x_q       <= x_d;
    status_q  <= status_d;
    out_key_q <= out_key_d;
    out_tag_q <= out_tag_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word shown while a sift is still running");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (IW'(mem_waddr) < IW'(count_q)))
    else $error("heap write outside the occupied slots");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i == bmhq_pkg::REQ_INSERT)
     && (count_q == CW'(CAPACITY)))
    |=> (done_o && (status_o == bmhq_pkg::STATUS_FULL) && $stable(count_q)))
    else $error("insert into a full heap not dropped");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmhq_pkg::ST_POP) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("remove did not reduce the entry count by one");
`endif

endmodule
